FILE: hw/rtl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg: shared types and constants for the running median tracker
// Data and count widths, operation codes and the per-cell control word.
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 7;
    localparam int CAPACITY_DEF = 64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic                     ins_en;
        logic                     rem_en;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/running_median_tracker_top.sv
// ----------------------------------------------------------------------------
// running_median_tracker_top: running lower median over a sorted cell row
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  s_      | s_valid s_ready s_opcode s_value            | in
//  m_      | m_valid m_ready m_accepted m_median_value   | out
//          | m_median_valid m_item_count                 |
//
// For each word, the row of compare-and-shift cells updates in
// the cycle the word is accepted, and the median tap is read into the output
// register in the next. A new word is taken once not busy and the result register frees.
// Reset (aresetn, synchronous) clears the count and handshake state only;
// cell contents are meaningless above the count. m_ready low stalls input.
// ----------------------------------------------------------------------------
module running_median_tracker_top #(
    parameter int CAPACITY = rmt_pkg::CAPACITY_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_opcode,
    input  logic signed [rmt_pkg::DATA_W-1:0]  s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_accepted,
    output logic signed [rmt_pkg::DATA_W-1:0]  m_median_value,
    output logic                               m_median_valid,
    output logic [rmt_pkg::COUNT_W-1:0]        m_item_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                     busy_reg;
    logic                     m_valid_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     ok_reg;
    logic                     accepted_reg;
    logic [rmt_pkg::DATA_W-1:0] median_reg;
    logic                     median_valid_reg;
    logic [rmt_pkg::COUNT_W-1:0] item_count_reg;

    logic                     take;
    logic                     found;
    logic                     ok;
    logic [CNT_W-1:0]         med_idx;
    logic [rmt_pkg::DATA_W-1:0] median_or;
    logic [CNT_W+rmt_pkg::COUNT_W-1:0] count_ext;
    rmt_pkg::cell_ctrl_t      ctrl;

    logic                              gt   [CAPACITY];
    logic                              eq   [CAPACITY];
    logic signed [rmt_pkg::DATA_W-1:0] data [CAPACITY];
    logic [rmt_pkg::DATA_W-1:0]        tap  [CAPACITY];

    assign s_ready = !busy_reg && (!m_valid_reg || m_ready);
    assign take    = s_valid && s_ready;

    always_comb begin
        found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            found = found | eq[i];
        end
    end

    always_comb begin
        ctrl.value  = s_value;
        ctrl.ins_en = 1'b0;
        ctrl.rem_en = 1'b0;
        ok          = 1'b0;
        count_next  = count_reg;
        if (take) begin
            if (s_opcode == rmt_pkg::OP_INSERT) begin
                if (count_reg < CAP_CNT) begin
                    ctrl.ins_en = 1'b1;
                    ok          = 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end else if (found) begin
                ctrl.rem_en = 1'b1;
                ok          = 1'b1;
                count_next  = count_reg - 1'b1;
            end
        end
    end

    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic                              l_gt;
            logic signed [rmt_pkg::DATA_W-1:0] l_data;
            logic signed [rmt_pkg::DATA_W-1:0] r_data;
            if (g == 0) begin : g_first
                assign l_gt   = 1'b0;
                assign l_data = '0;
            end else begin : g_mid
                assign l_gt   = gt[g-1];
                assign l_data = data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign r_data = '0;
            end else begin : g_inner
                assign r_data = data[g+1];
            end
            rmt_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .med_idx    (med_idx),
                .left_gt    (l_gt),
                .left_data  (l_data),
                .right_data (r_data),
                .gt         (gt[g]),
                .eq         (eq[g]),
                .data       (data[g]),
                .tap        (tap[g])
            );
        end
    endgenerate

    // lower median sits at (count - 1) / 2; only the matching cell drives its tap
    assign med_idx = (count_reg - 1'b1) >> 1;

    always_comb begin
        median_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            median_or = median_or | tap[i];
        end
    end

    assign count_ext = {{rmt_pkg::COUNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            ok_reg      <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (take) begin
                busy_reg <= 1'b1;
                ok_reg   <= ok;
            end else if (busy_reg) begin
                busy_reg <= 1'b0;
            end
            if (busy_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            accepted_reg     <= ok_reg;
            median_valid_reg <= count_reg != '0;
            median_reg       <= (count_reg != '0) ? median_or : '0;
            item_count_reg   <= count_ext[rmt_pkg::COUNT_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_accepted     = accepted_reg;
    assign m_median_value = median_reg;
    assign m_median_valid = median_valid_reg;
    assign m_item_count   = item_count_reg;

endmodule

FILE: hw/rtl/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell: one slot of the sorted row
// Holds one value; compares it with the broadcast word and takes the word,
// its left neighbour's value or its right neighbour's value.
// ----------------------------------------------------------------------------
module rmt_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                              aclk,
    input  rmt_pkg::cell_ctrl_t               ctrl,
    input  logic [CNT_W-1:0]                  count,
    input  logic [CNT_W-1:0]                  med_idx,
    input  logic                              left_gt,
    input  logic signed [rmt_pkg::DATA_W-1:0] left_data,
    input  logic signed [rmt_pkg::DATA_W-1:0] right_data,
    output logic                              gt,
    output logic                              eq,
    output logic signed [rmt_pkg::DATA_W-1:0] data,
    output logic [rmt_pkg::DATA_W-1:0]        tap
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic signed [rmt_pkg::DATA_W-1:0] data_reg;
    logic signed [rmt_pkg::DATA_W-1:0] data_next;
    logic                              occ;
    logic                              at_end;
    logic                              ge;

    assign occ    = count > MY_IDX;
    assign at_end = count == MY_IDX;
    assign gt     = occ && (ctrl.value < data_reg);
    assign ge     = occ && !(data_reg < ctrl.value);
    assign eq     = occ && (data_reg == ctrl.value);
    assign data   = data_reg;
    assign tap    = (med_idx == MY_IDX) ? data_reg : '0;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins_en) begin
            // larger values move right by one, the new word drops into the gap
            if (left_gt) begin
                data_next = left_data;
            end else if (gt || at_end) begin
                data_next = ctrl.value;
            end
        end else if (ctrl.rem_en) begin
            // duplicates shifting over each other is harmless
            if (ge) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

FILE: bench/running_median_tracker_top_test.sv
// ----------------------------------------------------------------------------
// running_median_tracker_top_test: self-checking bench for the median tracker
// Drives insert and remove words through the valid/ready input channel, keeps
// a sorted shadow of the held values to predict each result word, and checks
// every result field. A short directed table comes first; random traffic then
// sweeps the store between empty and full with bursty input and a stalling
// receiver.
// ----------------------------------------------------------------------------
module running_median_tracker_top_test;

    localparam int CAP        = rmt_pkg::CAPACITY_DEF;
    localparam int N_RANDOM   = 1530;
    localparam int N_DIRECTED = 21;

    localparam logic signed [rmt_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
    localparam logic signed [rmt_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

    typedef struct packed {
        logic                              accepted;
        logic signed [rmt_pkg::DATA_W-1:0] median_value;
        logic                              median_valid;
        logic [rmt_pkg::COUNT_W-1:0]       item_count;
    } median_res_t;

    typedef struct packed {
        logic                              op;
        logic signed [rmt_pkg::DATA_W-1:0] value;
        logic                              typed;
        median_res_t                       res;
    } stim_row_t;

    typedef struct packed {
        logic        typed;
        median_res_t res;
    } typed_tag_t;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} sweep_phase_t;
    typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

    localparam median_res_t NO_RES = '0;

    // typed results only where they are obvious; the rest come from the shadow
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{rmt_pkg::OP_REMOVE, 32'sd0,        1'b1, '{1'b0, 32'sd0,   1'b0, 7'd0}},
        '{rmt_pkg::OP_INSERT, VAL_MAX,       1'b1, '{1'b1, VAL_MAX,  1'b1, 7'd1}},
        '{rmt_pkg::OP_INSERT, VAL_MIN,       1'b1, '{1'b1, VAL_MIN,  1'b1, 7'd2}},
        '{rmt_pkg::OP_INSERT, 32'sd0,        1'b1, '{1'b1, 32'sd0,   1'b1, 7'd3}},
        '{rmt_pkg::OP_INSERT, -32'sd1,       1'b1, '{1'b1, -32'sd1,  1'b1, 7'd4}},
        '{rmt_pkg::OP_REMOVE, 32'sd5,        1'b1, '{1'b0, -32'sd1,  1'b1, 7'd4}},
        '{rmt_pkg::OP_INSERT, 32'sd0,        1'b0, NO_RES},
        '{rmt_pkg::OP_INSERT, 32'sd0,        1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, 32'sd0,        1'b0, NO_RES},
        '{rmt_pkg::OP_INSERT, 32'sh55555555, 1'b0, NO_RES},
        '{rmt_pkg::OP_INSERT, 32'shAAAAAAAA, 1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, VAL_MAX,       1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, VAL_MIN,       1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, 32'sd0,        1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, 32'sd0,        1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, -32'sd1,       1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, 32'sh55555555, 1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, 32'shAAAAAAAA, 1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, VAL_MIN,       1'b1, '{1'b0, 32'sd0,   1'b0, 7'd0}},
        '{rmt_pkg::OP_INSERT, 32'sd1,        1'b0, NO_RES},
        '{rmt_pkg::OP_REMOVE, 32'sd1,        1'b1, '{1'b1, 32'sd0,   1'b0, 7'd0}}
    };

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_valid  = 1'b0;
    logic                              s_ready;
    logic                              s_opcode = rmt_pkg::OP_INSERT;
    logic signed [rmt_pkg::DATA_W-1:0] s_value  = '0;
    logic                              m_valid;
    logic                              m_ready  = 1'b0;
    logic                              m_accepted;
    logic signed [rmt_pkg::DATA_W-1:0] m_median_value;
    logic                              m_median_valid;
    logic [rmt_pkg::COUNT_W-1:0]       m_item_count;

    // sorted shadow of the held values
    logic signed [rmt_pkg::DATA_W-1:0] row_vals [CAP];
    int                                row_n = 0;

    median_res_t                       median_exp_q [$];
    typed_tag_t                        typed_q [$];
    logic signed [rmt_pkg::DATA_W-1:0] stock [$];

    int words_sent    = 0;
    int results_seen  = 0;
    int fails         = 0;
    int full_refusals = 0;
    int absent_misses = 0;
    int peak_count    = 0;

    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;
    int       burst_left = 0;
    int       idle_gap   = 0;

    running_median_tracker_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_median_value (m_median_value),
        .m_median_valid (m_median_valid),
        .m_item_count   (m_item_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("running_median_tracker_top_test failed");
        $finish;
    end

    task automatic track_median(input logic op,
                                input logic signed [rmt_pkg::DATA_W-1:0] v,
                                output median_res_t r);
        int i;
        int hit;
        r.accepted = 1'b0;
        if (op == rmt_pkg::OP_INSERT) begin
            if (row_n < CAP) begin
                i = row_n;
                while (i > 0 && v < row_vals[i-1]) begin
                    row_vals[i] = row_vals[i-1];
                    i--;
                end
                row_vals[i] = v;
                row_n++;
                r.accepted = 1'b1;
            end
        end else begin
            hit = -1;
            for (i = 0; i < row_n; i++)
                if (hit < 0 && row_vals[i] == v)
                    hit = i;
            if (hit >= 0) begin
                for (i = hit; i < row_n - 1; i++)
                    row_vals[i] = row_vals[i+1];
                row_n--;
                r.accepted = 1'b1;
            end
        end
        r.median_valid = (row_n > 0);
        r.median_value = (row_n > 0) ? row_vals[(row_n - 1) / 2] : '0;
        r.item_count   = row_n[rmt_pkg::COUNT_W-1:0];
    endtask

    task automatic compare_field(input string fname, input int want, input int got);
        if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    // result words are checked before the input word of the same edge is queued
    always @(posedge aclk) begin
        median_res_t got;
        median_res_t want;
        typed_tag_t  tag;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                got = '{m_accepted, m_median_value, m_median_valid, m_item_count};
                if (median_exp_q.size() == 0) begin
                    fails++;
                    $display("%0t: result word with nothing expected, actual %p", $time, got);
                end else begin
                    want = median_exp_q.pop_front();
                    compare_field("accepted", want.accepted, got.accepted);
                    compare_field("median_value", want.median_value, got.median_value);
                    compare_field("median_valid", want.median_valid, got.median_valid);
                    compare_field("item_count", want.item_count, got.item_count);
                end
            end
            if (s_valid && s_ready) begin
                track_median(s_opcode, s_value, want);
                if (!want.accepted) begin
                    if (s_opcode == rmt_pkg::OP_INSERT) full_refusals++;
                    else absent_misses++;
                end
                if (row_n > peak_count) peak_count = row_n;
                tag = typed_q.pop_front();
                if (tag.typed) want = tag.res;
                median_exp_q.push_back(want);
            end
        end
    end

    // receiver: picks one of four stall patterns and redraws it when its run counter ends
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_HALF:   m_ready <= ($urandom_range(0, 1) == 0);
            RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
            default:   m_ready <= (rx_tick % 7 > 2);
        endcase
    end

    task automatic send_word(input logic op, input logic signed [rmt_pkg::DATA_W-1:0] v,
                             input logic typed, input median_res_t res, input logic drain);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            idle_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
            idle_gap = 0;
        end
        burst_left--;
        if (idle_gap > 0 || drain) begin
            s_valid <= 1'b0;
            repeat (idle_gap) @(posedge aclk);
            // hold off until the tracker has caught up completely
            if (drain) begin
                @(posedge aclk);
                while (results_seen != words_sent) @(posedge aclk);
            end
        end
        typed_q.push_back('{typed, res});
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    function automatic logic signed [rmt_pkg::DATA_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3, 4: return int'($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        sweep_phase_t                      phase;
        int                                edge_hits;
        int                                phase_left;
        int                                n;
        int                                k;
        logic                              op;
        logic signed [rmt_pkg::DATA_W-1:0] v;

        phase      = PH_FILL;
        edge_hits  = 0;
        phase_left = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (n = 0; n < N_DIRECTED; n++)
            send_word(DIRECTED[n].op, DIRECTED[n].value, DIRECTED[n].typed,
                      DIRECTED[n].res, 1'b0);

        // sweep between empty and full, with mixed stretches in between
        for (n = 0; n < N_RANDOM; n++) begin
            case (phase)
                PH_FILL: begin
                    op = ($urandom_range(0, 99) < 85) ? rmt_pkg::OP_INSERT
                                                      : rmt_pkg::OP_REMOVE;
                    if (stock.size() == CAP) begin
                        op = rmt_pkg::OP_INSERT;
                        edge_hits++;
                        if (edge_hits > 4) begin
                            phase     = PH_DRAIN;
                            edge_hits = 0;
                        end
                    end
                end
                PH_DRAIN: begin
                    op = ($urandom_range(0, 99) < 85) ? rmt_pkg::OP_REMOVE
                                                      : rmt_pkg::OP_INSERT;
                    if (stock.size() == 0) begin
                        op = rmt_pkg::OP_REMOVE;
                        edge_hits++;
                        if (edge_hits > 2) begin
                            phase      = PH_MIX;
                            edge_hits  = 0;
                            phase_left = $urandom_range(30, 120);
                        end
                    end
                end
                default: begin
                    op = 1'($urandom_range(0, 1));
                    if (phase_left == 0) phase = PH_FILL;
                    else phase_left--;
                end
            endcase

            if (op == rmt_pkg::OP_REMOVE && stock.size() > 0 &&
                $urandom_range(0, 99) < 85) begin
                k = $urandom_range(0, stock.size() - 1);
                v = stock[k];
                stock.delete(k);
            end else if (op == rmt_pkg::OP_REMOVE) begin
                v = $urandom;
            end else begin
                v = random_value();
                if (stock.size() < CAP) stock.push_back(v);
            end
            send_word(op, v, 1'b0, NO_RES, (n % 400 == 399));
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen != words_sent) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (median_exp_q.size() != 0) begin
            fails++;
            $display("%0t: %0d result words never arrived", $time, median_exp_q.size());
        end
        $display("%0d words checked, peak fill %0d of %0d", results_seen, peak_count, CAP);
        $display("%0d inserts refused when full, %0d removes of absent values",
                 full_refusals, absent_misses);
        if (fails == 0)
            $display("running_median_tracker_top_test passed");
        else
            $display("running_median_tracker_top_test failed");
        $finish;
    end

endmodule
